>>> rtl/core/assert_macros.svh
// Assertion helpers for the RTL, included by the top-level queue module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> rtl/core/tep_pkg.sv
package tep_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int FUNC_W    = 2;
    localparam int ID_W      = 8;
    localparam int DLY_W     = 16;
    localparam int CNT_OUT_W = 5;

    // Operation codes; the fourth code does nothing
    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_CLEAR  = 2'd2
    } t_func;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the incoming word
        logic exec;   // apply the captured operation
    } t_dp_cmd;

endpackage

>>> rtl/core/tep_ctrl.sv
module tep_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output tep_pkg::t_dp_cmd o_cmd
);
    import tep_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // Sequence: capture, execute, present result
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state != S_IDLE);
    assign o_done     = (r_state == S_DONE);
    assign o_cmd.load = (r_state == S_IDLE) && start;
    assign o_cmd.exec = (r_state == S_EXEC);

endmodule

>>> rtl/core/tep_datapath.sv
module tep_datapath #(
    parameter int DEPTH = tep_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tep_pkg::t_dp_cmd              i_cmd,
    input  logic [tep_pkg::FUNC_W-1:0]    i_func,
    input  logic [tep_pkg::ID_W-1:0]      i_actor_id,
    input  logic [tep_pkg::DLY_W-1:0]     i_new_delay,
    output logic [tep_pkg::ID_W-1:0]      o_popped_id,
    output logic [tep_pkg::DLY_W-1:0]     o_popped_delay,
    output logic                          o_was_empty,
    output logic                          o_dropped_full,
    output logic [tep_pkg::CNT_OUT_W-1:0] o_entries_now
);
    import tep_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // Captured word
    logic [FUNC_W-1:0] r_func;
    logic [ID_W-1:0]   r_id;
    logic [DLY_W-1:0]  r_dly;

    // Sorted cell chain, head at index 0
    logic [ID_W-1:0]   r_ids  [DEPTH];
    logic [DLY_W-1:0]  r_dlys [DEPTH];
    logic [ID_W-1:0]   n_ids  [DEPTH];
    logic [DLY_W-1:0]  n_dlys [DEPTH];
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // Result registers
    logic [ID_W-1:0]   r_pid;
    logic [DLY_W-1:0]  r_pdly;
    logic              r_empty;
    logic              r_drop;
    logic [ID_W-1:0]   n_pid;
    logic [DLY_W-1:0]  n_pdly;
    logic              n_empty;
    logic              n_drop;

    // Per-cell "stays ahead of the new entry" flags
    logic [DEPTH-1:0]  le;
    logic [DEPTH-1:0]  le_prev;

    always_comb begin
        for (int k = 0; k < DEPTH; k++) begin
            le[k] = (CW'(k) < r_count) && (r_dlys[k] <= r_dly);
        end
        le_prev = {le[DEPTH-2:0], 1'b1};
    end

    // Compute next chain contents and result
    always_comb begin
        n_ids   = r_ids;
        n_dlys  = r_dlys;
        n_count = r_count;
        n_pid   = '0;
        n_pdly  = '0;
        n_empty = 1'b0;
        n_drop  = 1'b0;
        case (r_func)
            FUNC_INSERT: begin
                if (r_count >= CW'(DEPTH)) begin
                    n_drop = 1'b1;
                end else begin
                    // Cells ahead hold, the gap takes the new entry, the rest shift back
                    if (!le[0]) begin
                        n_ids[0]  = r_id;
                        n_dlys[0] = r_dly;
                    end
                    for (int k = 1; k < DEPTH; k++) begin
                        if (!le[k]) begin
                            if (le_prev[k]) begin
                                n_ids[k]  = r_id;
                                n_dlys[k] = r_dly;
                            end else begin
                                n_ids[k]  = r_ids[k-1];
                                n_dlys[k] = r_dlys[k-1];
                            end
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            FUNC_POP: begin
                if (r_count == '0) begin
                    n_empty = 1'b1;
                end else begin
                    // Drop the head, advance the rest and rebase their delays
                    n_pid  = r_ids[0];
                    n_pdly = r_dlys[0];
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        n_ids[k]  = r_ids[k+1];
                        n_dlys[k] = r_dlys[k+1] - r_dlys[0];
                    end
                    n_count = r_count - CW'(1);
                end
            end
            FUNC_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // Capture the incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_id   <= i_actor_id;
            r_dly  <= i_new_delay;
        end
    end

    // Update chain and result
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ids   <= n_ids;
            r_dlys  <= n_dlys;
            r_pid   <= n_pid;
            r_pdly  <= n_pdly;
            r_empty <= n_empty;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_popped_id    = r_pid;
    assign o_popped_delay = r_pdly;
    assign o_was_empty    = r_empty;
    assign o_dropped_full = r_drop;
    assign o_entries_now  = CNT_OUT_W'(r_count);

endmodule

>>> rtl/core/timed_event_priority_queue.sv
// Channel   Direction  Handshake            Words
// command   in         start high, busy low i_func, i_actor_id, i_new_delay
// result    out        o_done one cycle     o_popped_id, o_popped_delay, o_was_empty,
//                                           o_dropped_full, o_entries_now
//
// Each command passes through capture, an execute step in which the whole cell
// chain compares and shifts in parallel, then one cycle with o_done high.
// busy is high from the cycle after acceptance until the result has been shown.
// Synchronous active-low reset empties the queue; cell contents are not cleared.
// The receiver cannot stall; the result is valid only while o_done is high.
`include "assert_macros.svh"

module timed_event_priority_queue #(
    parameter int DEPTH = tep_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tep_pkg::FUNC_W-1:0]    i_func,
    input  logic [tep_pkg::ID_W-1:0]      i_actor_id,
    input  logic [tep_pkg::DLY_W-1:0]     i_new_delay,
    output logic                          o_done,
    output logic [tep_pkg::ID_W-1:0]      o_popped_id,
    output logic [tep_pkg::DLY_W-1:0]     o_popped_delay,
    output logic                          o_was_empty,
    output logic                          o_dropped_full,
    output logic [tep_pkg::CNT_OUT_W-1:0] o_entries_now
);
    import tep_pkg::*;

    t_dp_cmd cmd;

    tep_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (cmd)
    );

    tep_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_func         (i_func),
        .i_actor_id     (i_actor_id),
        .i_new_delay    (i_new_delay),
        .o_popped_id    (o_popped_id),
        .o_popped_delay (o_popped_delay),
        .o_was_empty    (o_was_empty),
        .o_dropped_full (o_dropped_full),
        .o_entries_now  (o_entries_now)
    );

    `ASSERT_AT(a_accept_busy, i_clk, i_rst_n, (start && !busy) |=> (busy && !o_done), "accepted word did not raise busy")
    `ASSERT_AT(a_single_strobe, i_clk, i_rst_n, o_done |=> !o_done, "result strobe longer than one cycle")
    `ASSERT_NEVER(a_flags_excl, i_clk, i_rst_n, o_done && o_was_empty && o_dropped_full, "empty and full flags together")
    `ASSERT_AT(a_empty_pop, i_clk, i_rst_n, (o_done && o_was_empty) |-> (o_entries_now == '0 && o_popped_id == '0), "empty pop with nonzero result")

endmodule

>>> sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tep_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    // Spare operation code: the block leaves the queue as it is
    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    // Cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // Idle cycles after the last result, to catch stray words
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [ID_W-1:0]      id;
        logic [DLY_W-1:0]     dly;
        logic                 empty;
        logic                 full;
        logic [CNT_OUT_W-1:0] count;
    } t_result;

    // Sorted-queue predictor plus a FIFO of expected result words
    class queue_checker;
        logic [ID_W-1:0]  ids[DEPTH];
        logic [DLY_W-1:0] dlys[DEPTH];
        int               count;
        int               errors;
        t_result          pending[$];

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Apply one accepted command and queue the word it must produce
        function void note_command(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                   logic [DLY_W-1:0] dly);
            t_result r;
            int      pos;
            r = '0;
            case (f)
                FUNC_INSERT: begin
                    if (count >= DEPTH) begin
                        r.full = 1'b1;
                    end else begin
                        // walk past every entry with a delay not above the new one
                        pos = 0;
                        while (pos < count && dlys[pos] <= dly) pos++;
                        for (int k = count; k > pos; k--) begin
                            ids[k]  = ids[k-1];
                            dlys[k] = dlys[k-1];
                        end
                        ids[pos]  = id;
                        dlys[pos] = dly;
                        count++;
                    end
                end
                FUNC_POP: begin
                    if (count == 0) begin
                        r.empty = 1'b1;
                    end else begin
                        // remove the head and age the rest by its delay
                        r.id  = ids[0];
                        r.dly = dlys[0];
                        for (int k = 1; k < count; k++) begin
                            ids[k-1]  = ids[k];
                            dlys[k-1] = dlys[k] - r.dly;
                        end
                        count--;
                    end
                end
                FUNC_CLEAR: count = 0;
                default: ;
            endcase
            r.count = count[CNT_OUT_W-1:0];
            pending.push_back(r);
        endfunction

        // Compare one result word with the oldest expectation
        function void check_word(t_result act);
            t_result exp;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (act.id !== exp.id) begin
                $error("popped_id: expected %0d, actual %0d", exp.id, act.id);
                errors++;
            end
            if (act.dly !== exp.dly) begin
                $error("popped_delay: expected %0d, actual %0d", exp.dly, act.dly);
                errors++;
            end
            if (act.empty !== exp.empty) begin
                $error("was_empty: expected %0d, actual %0d", exp.empty, act.empty);
                errors++;
            end
            if (act.full !== exp.full) begin
                $error("dropped_full: expected %0d, actual %0d", exp.full, act.full);
                errors++;
            end
            if (act.count !== exp.count) begin
                $error("entries_now: expected %0d, actual %0d", exp.count, act.count);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func;
    logic [ID_W-1:0]      i_actor_id;
    logic [DLY_W-1:0]     i_new_delay;
    logic                 o_done;
    logic [ID_W-1:0]      o_popped_id;
    logic [DLY_W-1:0]     o_popped_delay;
    logic                 o_was_empty;
    logic                 o_dropped_full;
    logic [CNT_OUT_W-1:0] o_entries_now;

    queue_checker chk = new();
    int           idle_pct;
    int           hang_count;
    t_result      seen;

    timed_event_priority_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_actor_id     (i_actor_id),
        .i_new_delay    (i_new_delay),
        .o_done         (o_done),
        .o_popped_id    (o_popped_id),
        .o_popped_delay (o_popped_delay),
        .o_was_empty    (o_was_empty),
        .o_dropped_full (o_dropped_full),
        .o_entries_now  (o_entries_now)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Present one command word, with an optional random gap ahead of it
    task automatic send_word(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                             logic [DLY_W-1:0] dly);
        int n;
        n = 0;
        while (n < 20 && $urandom_range(0, 99) < idle_pct) n++;
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_func      <= f;
        i_actor_id  <= id;
        i_new_delay <= dly;
        do @(posedge i_clk); while (busy);
        chk.note_command(f, id, dly);
    endtask

    // Mix of extremes, tight ranges that force ties, and full-range delays
    function automatic logic [DLY_W-1:0] pick_delay();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return DLY_W'($urandom_range(0, 15));
            5, 6:    return DLY_W'($urandom_range(0, 1023));
            default: return DLY_W'($urandom());
        endcase
    endfunction

    // Bursts with a drifting insert/pop balance so the queue swings
    // between empty and full
    task automatic run_random(int items);
        int insert_pct;
        int r;
        insert_pct = 50;
        for (int i = 0; i < items; i++) begin
            if (i % 40 == 0) insert_pct = $urandom_range(15, 85);
            r = $urandom_range(0, 99);
            if (r < 3)
                send_word(FUNC_CLEAR, ID_W'($urandom()), DLY_W'($urandom()));
            else if (r < 5)
                send_word(FUNC_NOP, ID_W'($urandom()), DLY_W'($urandom()));
            else if (r < 5 + insert_pct * 95 / 100)
                send_word(FUNC_INSERT, ID_W'($urandom()), pick_delay());
            else
                send_word(FUNC_POP, ID_W'($urandom()), DLY_W'($urandom()));
        end
    endtask

    // Stimulus and end of run
    initial begin
        idle_pct    = 0;
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_func      <= FUNC_INSERT;
        i_actor_id  <= '0;
        i_new_delay <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue corners
        send_word(FUNC_POP, 8'hFF, 16'hFFFF);
        send_word(FUNC_NOP, 8'h00, 16'h0000);
        send_word(FUNC_CLEAR, 8'hA5, 16'h5A5A);
        // Extremes, then ties that must keep arrival order
        send_word(FUNC_INSERT, 8'hFF, 16'hFFFF);
        send_word(FUNC_INSERT, 8'h00, 16'h0000);
        send_word(FUNC_INSERT, 8'h01, 16'd100);
        send_word(FUNC_INSERT, 8'h02, 16'd100);
        send_word(FUNC_INSERT, 8'h03, 16'h0000);
        // Fill to the top, then one more that must drop
        for (int k = 5; k < DEPTH; k++)
            send_word(FUNC_INSERT, ID_W'($urandom()), DLY_W'($urandom_range(0, 300)));
        send_word(FUNC_INSERT, 8'h77, 16'd50);
        send_word(FUNC_POP, 8'h00, 16'h0000);
        send_word(FUNC_POP, 8'h00, 16'h0000);
        send_word(FUNC_NOP, 8'hFF, 16'hFFFF);
        send_word(FUNC_CLEAR, 8'h00, 16'h0000);
        send_word(FUNC_POP, 8'h00, 16'h0000);

        // Random phases: sender idles often, more often, then never
        idle_pct = 38;
        run_random(310);
        idle_pct = 55;
        run_random(310);
        idle_pct = 0;
        run_random(310);
        start <= 1'b0;

        while (chk.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Capture each result word on its strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen.id    = o_popped_id;
            seen.dly   = o_popped_delay;
            seen.empty = o_was_empty;
            seen.full  = o_dropped_full;
            seen.count = o_entries_now;
            chk.check_word(seen);
        end
    end

    // Abort when no word moves in either direction for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            hang_count <= 0;
        end else if (hang_count >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            hang_count <= hang_count + 1;
        end
    end

endmodule
